// File: sv/d2s3_pkg.sv
// shared types, widths and helper functions for the 3-D depth-to-space reorder block
// used by every module of the block; depends on nothing
package d2s3_pkg;

    localparam int IDX_W   = 38;  // destination index width
    localparam int VAL_W   = 32;  // element value width
    localparam int LIM_W   = 13;  // clamped loop limits, up to 4096
    localparam int OW_W    = 12;  // output row width, up to 2 * 2047
    localparam int RSTEP_W = 13;  // row step, up to 4 * 2047
    localparam int ROW_W   = 24;  // row offset inside one time slice
    localparam int COL_W   = 12;  // column term inside one output row
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // register indexes
    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_WIDTH    = 3'd1;
    localparam logic [2:0] REG_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_FRAMES   = 3'd3;
    localparam logic [2:0] REG_TRATIO   = 3'd4;
    localparam logic [2:0] REG_SRATIO   = 3'd5;
    localparam logic [2:0] REG_DROP     = 3'd6;

    // geometry derived from the configuration registers
    typedef struct packed {
        logic [LIM_W-1:0]   nc;
        logic [LIM_W-1:0]   nw;
        logic [LIM_W-1:0]   nh;
        logic [LIM_W-1:0]   nf;
        logic               t2;        // temporal factor is two
        logic               s2;        // spatial factor is two
        logic               dropping;  // head removal active
        logic               two_slices;
        logic [OW_W-1:0]    ow;
        logic [RSTEP_W-1:0] rstep;
    } t_geom;

    // one kept element on its way from the front to the back
    typedef struct packed {
        logic [IDX_W-1:0] tbase;
        logic [ROW_W-1:0] row_off;
        logic [COL_W-1:0] col_term;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_item;

    function automatic logic [LIM_W-1:0] f_clamp(input logic [15:0] v,
                                                 input logic [15:0] hi);
        logic [15:0] r;
        begin
            if (v == 16'd0) begin
                r = 16'd1;
            end else if (v > hi) begin
                r = hi;
            end else begin
                r = v;
            end
            return r[LIM_W-1:0];
        end
    endfunction

endpackage

// File: sv/d2s3_cfg.sv
// configuration registers behind the apb-style port and the derived geometry
// depends on d2s3_pkg
module d2s3_cfg #(
    parameter int MAX_CHANNELS = 512,
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_FRAMES   = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [d2s3_pkg::ADDR_W-1:0] paddr,
    input  logic [d2s3_pkg::DATA_W-1:0] pwdata,
    output logic [d2s3_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output d2s3_pkg::t_geom            o_geom,
    output logic                       o_clear
);

    logic [9:0]  r_channel_count;
    logic [10:0] r_in_width;
    logic [10:0] r_in_height;
    logic [6:0]  r_in_frames;
    logic [1:0]  r_time_ratio;
    logic [1:0]  r_space_ratio;
    logic        r_drop_head;

    logic [2:0]  w_index;
    logic        w_write;
    logic        w_hit;

    assign pready  = 1'b1;
    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite;
    assign w_hit   = (w_index == d2s3_pkg::REG_CHANNELS) || (w_index == d2s3_pkg::REG_WIDTH)
                  || (w_index == d2s3_pkg::REG_HEIGHT) || (w_index == d2s3_pkg::REG_FRAMES)
                  || (w_index == d2s3_pkg::REG_TRATIO) || (w_index == d2s3_pkg::REG_SRATIO)
                  || (w_index == d2s3_pkg::REG_DROP);
    assign o_clear = w_write && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 10'd1;
            r_in_width      <= 11'd1;
            r_in_height     <= 11'd1;
            r_in_frames     <= 7'd1;
            r_time_ratio    <= 2'd1;
            r_space_ratio   <= 2'd1;
            r_drop_head     <= 1'b0;
        end else if (w_write) begin
            case (w_index)
                d2s3_pkg::REG_CHANNELS: r_channel_count <= pwdata[9:0];
                d2s3_pkg::REG_WIDTH:    r_in_width      <= pwdata[10:0];
                d2s3_pkg::REG_HEIGHT:   r_in_height     <= pwdata[10:0];
                d2s3_pkg::REG_FRAMES:   r_in_frames     <= pwdata[6:0];
                d2s3_pkg::REG_TRATIO:   r_time_ratio    <= pwdata[1:0];
                d2s3_pkg::REG_SRATIO:   r_space_ratio   <= pwdata[1:0];
                d2s3_pkg::REG_DROP:     r_drop_head     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            d2s3_pkg::REG_CHANNELS: prdata = {22'd0, r_channel_count};
            d2s3_pkg::REG_WIDTH:    prdata = {21'd0, r_in_width};
            d2s3_pkg::REG_HEIGHT:   prdata = {21'd0, r_in_height};
            d2s3_pkg::REG_FRAMES:   prdata = {25'd0, r_in_frames};
            d2s3_pkg::REG_TRATIO:   prdata = {30'd0, r_time_ratio};
            d2s3_pkg::REG_SRATIO:   prdata = {30'd0, r_space_ratio};
            d2s3_pkg::REG_DROP:     prdata = {31'd0, r_drop_head};
            default:                prdata = '0;
        endcase
    end

    logic [d2s3_pkg::LIM_W-1:0] w_nw;
    logic [d2s3_pkg::LIM_W-1:0] w_nf;
    logic                       w_t2;
    logic                       w_s2;

    assign w_nw = d2s3_pkg::f_clamp({5'd0, r_in_width}, 16'(MAX_WIDTH));
    assign w_nf = d2s3_pkg::f_clamp({9'd0, r_in_frames}, 16'(MAX_FRAMES));
    assign w_t2 = r_time_ratio >= 2'd2;
    assign w_s2 = r_space_ratio >= 2'd2;

    always_comb begin
        o_geom.nc = d2s3_pkg::f_clamp({6'd0, r_channel_count}, 16'(MAX_CHANNELS));
        o_geom.nw = w_nw;
        o_geom.nh = d2s3_pkg::f_clamp({5'd0, r_in_height}, 16'(MAX_HEIGHT));
        o_geom.nf = w_nf;
        o_geom.t2 = w_t2;
        o_geom.s2 = w_s2;
        // head removal needs at least two source time slices
        o_geom.dropping   = r_drop_head && (w_t2 || (w_nf != d2s3_pkg::LIM_W'(1)));
        o_geom.two_slices = (w_t2 && (w_nf == d2s3_pkg::LIM_W'(1)))
                         || (!w_t2 && (w_nf == d2s3_pkg::LIM_W'(2)));
        o_geom.ow    = w_s2 ? d2s3_pkg::OW_W'({w_nw, 1'b0}) : d2s3_pkg::OW_W'(w_nw);
        o_geom.rstep = w_s2 ? d2s3_pkg::RSTEP_W'({w_nw, 2'b00})
                            : d2s3_pkg::RSTEP_W'(w_nw);
    end

endmodule

// File: sv/d2s3_front.sv
// front end: position counters, drop classification and partial address terms
// depends on d2s3_pkg
module d2s3_front #(
    parameter int MAX_CHANNELS = 512,
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_FRAMES   = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  d2s3_pkg::t_geom             i_geom,
    input  logic                        i_clear,
    input  logic                        i_accept,
    input  logic [d2s3_pkg::VAL_W-1:0]  i_value,
    output logic                        o_keep,
    output d2s3_pkg::t_item             o_item
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WD_W  = (MAX_WIDTH > 1)    ? $clog2(MAX_WIDTH)    : 1;
    localparam int HT_W  = (MAX_HEIGHT > 1)   ? $clog2(MAX_HEIGHT)   : 1;
    localparam int FR_W  = (MAX_FRAMES > 1)   ? $clog2(MAX_FRAMES)   : 1;
    localparam int LW    = d2s3_pkg::LIM_W;

    logic [CH_W-1:0]              r_chan, n_chan;
    logic [FR_W-1:0]              r_frame, n_frame;
    logic                         r_tph, n_tph;
    logic                         r_rph, n_rph;
    logic                         r_cph, n_cph;
    logic [HT_W-1:0]              r_row, n_row;
    logic [WD_W-1:0]              r_col, n_col;
    logic [d2s3_pkg::ROW_W-1:0]   r_row_off, n_row_off;
    logic [d2s3_pkg::IDX_W-1:0]   r_kept, n_kept;   // kept transactions so far in this tensor
    logic [d2s3_pkg::IDX_W-1:0]   r_tbase, n_tbase; // kept count at start of this time slice

    logic w_col_wrap, w_row_wrap, w_cph_wrap, w_rph_wrap, w_tph_wrap, w_frm_wrap, w_chn_wrap;
    logic c0, c1, c2, c3, c4, c5, c6;
    logic w_src_one, w_last_slice, w_last;

    always_comb begin
        w_col_wrap = LW'(r_col) + LW'(1) >= i_geom.nw;
        w_row_wrap = LW'(r_row) + LW'(1) >= i_geom.nh;
        w_cph_wrap = !i_geom.s2 || r_cph;
        w_rph_wrap = !i_geom.s2 || r_rph;
        w_tph_wrap = !i_geom.t2 || r_tph;
        w_frm_wrap = LW'(r_frame) + LW'(1) >= i_geom.nf;
        w_chn_wrap = LW'(r_chan) + LW'(1) >= i_geom.nc;

        c0 = w_col_wrap;
        c1 = c0 && w_row_wrap;
        c2 = c1 && w_cph_wrap;
        c3 = c2 && w_rph_wrap;   // end of a time slice
        c4 = c3 && w_tph_wrap;
        c5 = c4 && w_frm_wrap;
        c6 = c5 && w_chn_wrap;   // end of the tensor

        // source time one is the slice that head removal drops
        w_src_one = i_geom.t2 ? ((r_frame == '0) && r_tph)
                              : (LW'(r_frame) == LW'(1));
        o_keep    = !(i_geom.dropping && w_src_one);

        if (i_geom.dropping && i_geom.two_slices) begin
            w_last_slice = (r_frame == '0) && !r_tph;
        end else begin
            w_last_slice = (LW'(r_frame) == i_geom.nf - LW'(1)) && (r_tph == i_geom.t2);
        end
        w_last = (LW'(r_chan) == i_geom.nc - LW'(1)) && w_last_slice
              && (r_rph == i_geom.s2) && (r_cph == i_geom.s2)
              && (LW'(r_row) == i_geom.nh - LW'(1))
              && (LW'(r_col) == i_geom.nw - LW'(1));

        o_item.tbase    = r_tbase;
        o_item.row_off  = r_row_off;
        o_item.col_term = i_geom.s2 ? d2s3_pkg::COL_W'({r_col, r_cph})
                                    : d2s3_pkg::COL_W'(r_col);
        o_item.value    = i_value;
        o_item.last     = w_last;
    end

    always_comb begin
        n_col     = c0 ? '0 : r_col + WD_W'(1);
        n_row     = r_row;
        n_cph     = r_cph;
        n_rph     = r_rph;
        n_tph     = r_tph;
        n_frame   = r_frame;
        n_chan    = r_chan;
        n_row_off = r_row_off;
        n_kept    = r_kept + d2s3_pkg::IDX_W'(o_keep);
        n_tbase   = r_tbase;
        if (c0) begin
            n_row = w_row_wrap ? '0 : r_row + HT_W'(1);
        end
        if (c1) begin
            n_cph = w_cph_wrap ? 1'b0 : 1'b1;
        end
        if (c2) begin
            n_rph = w_rph_wrap ? 1'b0 : 1'b1;
        end
        if (c3) begin
            n_tph = w_tph_wrap ? 1'b0 : 1'b1;
        end
        if (c4) begin
            n_frame = w_frm_wrap ? '0 : r_frame + FR_W'(1);
        end
        if (c5) begin
            n_chan = w_chn_wrap ? '0 : r_chan + CH_W'(1);
        end
        // row offset tracks (row * s + row phase) * output width
        if (c0) begin
            if (!w_row_wrap) begin
                n_row_off = r_row_off + d2s3_pkg::ROW_W'(i_geom.rstep);
            end else begin
                n_row_off = n_rph ? d2s3_pkg::ROW_W'(i_geom.ow) : '0;
            end
        end
        if (c3) begin
            n_tbase = n_kept;
        end
        if (c6) begin
            n_kept  = '0;
            n_tbase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_chan    <= '0;
            r_frame   <= '0;
            r_tph     <= 1'b0;
            r_rph     <= 1'b0;
            r_cph     <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_row_off <= '0;
            r_kept    <= '0;
            r_tbase   <= '0;
        end else if (i_accept) begin
            r_chan    <= n_chan;
            r_frame   <= n_frame;
            r_tph     <= n_tph;
            r_rph     <= n_rph;
            r_cph     <= n_cph;
            r_row     <= n_row;
            r_col     <= n_col;
            r_row_off <= n_row_off;
            r_kept    <= n_kept;
            r_tbase   <= n_tbase;
        end
    end

endmodule

// File: sv/d2s3_fifo.sv
// short queue that decouples the front end from the address back end
// depends on d2s3_pkg
module d2s3_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  d2s3_pkg::t_item i_item,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_valid,
    output d2s3_pkg::t_item o_item
);

    localparam int AW = d2s3_pkg::FIFO_AW;

    d2s3_pkg::t_item  r_mem [d2s3_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [AW:0]      r_count;

    logic w_do_wr, w_do_rd;

    assign o_full  = r_count == (AW+1)'(d2s3_pkg::FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rptr];
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_wr) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (w_do_rd) begin
                r_rptr <= r_rptr + AW'(1);
            end
            case ({w_do_wr, w_do_rd})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: ;
            endcase
        end
    end

endmodule

// File: sv/d2s3_back.sv
// back end: final address sum and the result output register
// depends on d2s3_pkg
module d2s3_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  d2s3_pkg::t_item             i_item,
    output logic                        o_take,
    output logic                        empty,
    input  logic                        pop,
    output logic [d2s3_pkg::IDX_W-1:0]  o_dest_index,
    output logic [d2s3_pkg::VAL_W-1:0]  o_out_value,
    output logic                        o_last_element
);

    logic r_valid;

    assign empty  = !r_valid;
    // refill the output register in the cycle it is emptied
    assign o_take = i_valid && (!r_valid || pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            o_dest_index   <= i_item.tbase
                            + d2s3_pkg::IDX_W'(i_item.row_off)
                            + d2s3_pkg::IDX_W'(i_item.col_term);
            o_out_value    <= i_item.value;
            o_last_element <= i_item.last;
        end
    end

endmodule

// File: sv/depth_to_space_3d_reorder_top.sv
// a kept element is written into the queue and then into the result output register,
// where it shows on the result ports and stays until it is popped
// one element per cycle while not full; the front counters advance once per accepted push
// dropped head elements advance the counters and give no result transaction
// reset (synchronous, active low) clears counters and queues and sets registers to defaults
// a register write also restarts all position counters at zero
module depth_to_space_3d_reorder_top #(
    parameter int MAX_CHANNELS = 512,
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_FRAMES   = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [d2s3_pkg::ADDR_W-1:0] paddr,
    input  logic [d2s3_pkg::DATA_W-1:0] pwdata,
    output logic [d2s3_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [d2s3_pkg::VAL_W-1:0]  i_element_value,
    output logic                        empty,
    input  logic                        pop,
    output logic [d2s3_pkg::IDX_W-1:0]  o_dest_index,
    output logic [d2s3_pkg::VAL_W-1:0]  o_out_value,
    output logic                        o_last_element
);

    d2s3_pkg::t_geom w_geom;
    d2s3_pkg::t_item w_front_item;
    d2s3_pkg::t_item w_back_item;
    logic            w_clear;
    logic            w_accept;
    logic            w_keep;
    logic            w_fifo_valid;
    logic            w_take;

    assign w_accept = push && !full;

    d2s3_cfg #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_FRAMES  (MAX_FRAMES)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_geom (w_geom),
        .o_clear(w_clear)
    );

    d2s3_front #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_FRAMES  (MAX_FRAMES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_clear (w_clear),
        .i_accept(w_accept),
        .i_value (i_element_value),
        .o_keep  (w_keep),
        .o_item  (w_front_item)
    );

    d2s3_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_accept && w_keep),
        .i_item (w_front_item),
        .i_rd   (w_take),
        .o_full (full),
        .o_valid(w_fifo_valid),
        .o_item (w_back_item)
    );

    d2s3_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_fifo_valid),
        .i_item        (w_back_item),
        .o_take        (w_take),
        .empty         (empty),
        .pop           (pop),
        .o_dest_index  (o_dest_index),
        .o_out_value   (o_out_value),
        .o_last_element(o_last_element)
    );

endmodule
